// ----- sv/base64_stream_encoder_macros.svh -----
// assertion helpers used by the encoder back unit
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

// same-cycle implication, checked on every rising clk outside reset
`define B64E_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define B64E_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/b64e_pkg.sv -----
package b64e_pkg;

	localparam int CHAR_W          = 7;
	localparam int CNT_W           = 16;
	localparam int MAX_CHARS       = 4;
	localparam int N_W             = 3;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [CNT_W-1:0]  CAP_RESET = 16'hFFFF;
	localparam logic [CHAR_W-1:0] PAD_CHAR  = 7'h3D;
	localparam logic [CHAR_W-1:0] PLUS_CHAR = 7'h2B;
	localparam logic [CHAR_W-1:0] SLASH_CHAR = 7'h2F;
	localparam logic [5:0]        SEXTET_MASK = 6'h3F;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       is_last;
	} in_word_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              char_valid;
		logic              stream_end;
		logic              overflow;
		logic [CNT_W-1:0]  char_count;
	} out_word_t;

	// characters one input item turns into, before the capacity check
	typedef struct packed {
		logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
		logic [N_W-1:0]                   n;
		logic                             last;
	} job_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

	function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] v);
		logic [5:0] s;
		s = v & SEXTET_MASK;
		if (s < 6'd26) begin
			return CHAR_W'(s) + 7'h41;
		end else if (s < 6'd52) begin
			return CHAR_W'(s - 6'd26) + 7'h61;
		end else if (s < 6'd62) begin
			return CHAR_W'(s - 6'd52) + 7'h30;
		end else if (s == 6'd62) begin
			return PLUS_CHAR;
		end else begin
			return SLASH_CHAR;
		end
	endfunction

endpackage

// ----- sv/b64e_front.sv -----
module b64e_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  b64e_pkg::in_word_t in_word,
	input  logic              q_full,
	output logic              enq,
	output b64e_pkg::job_t    job
);
	import b64e_pkg::*;

	logic [1:0] phase_q;
	logic [3:0] left_q;
	logic [1:0] phase_n;
	logic [3:0] left_n;
	logic [1:0] i0;
	logic [1:0] i1;
	logic [1:0] i2;
	logic [7:0] b;
	logic       accept;

	assign accept = push && !q_full;
	assign b      = in_word.data_byte;
	assign enq    = accept && (in_word.byte_present || in_word.is_last);

	always_comb begin
		job     = '0;
		phase_n = phase_q;
		left_n  = left_q;
		if (in_word.byte_present) begin
			case (phase_q)
				2'd0: begin
					job.chars[0] = sextet_char(b[7:2]);
					job.n        = 3'd1;
					left_n       = {2'b00, b[1:0]};
					phase_n      = 2'd1;
				end
				2'd1: begin
					job.chars[0] = sextet_char({left_q[1:0], b[7:4]});
					job.n        = 3'd1;
					left_n       = b[3:0];
					phase_n      = 2'd2;
				end
				default: begin
					job.chars[0] = sextet_char({left_q, b[7:6]});
					job.chars[1] = sextet_char(b[5:0]);
					job.n        = 3'd2;
					left_n       = 4'd0;
					phase_n      = 2'd0;
				end
			endcase
		end
		i0 = job.n[1:0];
		i1 = i0 + 2'd1;
		i2 = i0 + 2'd2;
		job.last = in_word.is_last;
		if (in_word.is_last) begin
			// flush the partial group and pad it out
			case (phase_n)
				2'd1: begin
					job.chars[i0] = sextet_char({left_n[1:0], 4'b0000});
					job.chars[i1] = PAD_CHAR;
					job.chars[i2] = PAD_CHAR;
					job.n         = job.n + 3'd3;
				end
				2'd2: begin
					job.chars[i0] = sextet_char({left_n, 2'b00});
					job.chars[i1] = PAD_CHAR;
					job.n         = job.n + 3'd2;
				end
				default: begin
				end
			endcase
			phase_n = 2'd0;
			left_n  = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			left_q  <= 4'd0;
		end else if (accept) begin
			phase_q <= phase_n;
			left_q  <= left_n;
		end
	end

endmodule

// ----- sv/b64e_queue.sv -----
module b64e_queue #(
	parameter int DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             enq,
	input  b64e_pkg::job_t   enq_job,
	input  logic             deq,
	output b64e_pkg::job_t   head,
	output b64e_pkg::q_stat_t stat
);
	import b64e_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W_Q = $clog2(DEPTH + 1);

	job_t              slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W_Q-1:0] fill_q;

	assign head       = slot_q[rd_ptr_q];
	assign stat.valid = (fill_q != '0);
	assign stat.full  = (fill_q == CNT_W_Q'(DEPTH));

	always_ff @(posedge clk) begin
		if (enq) begin
			slot_q[wr_ptr_q] <= enq_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				fill_q <= fill_q + 1'b1;
			end else if (deq && !enq) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/b64e_back.sv -----
`include "base64_stream_encoder_macros.svh"

module b64e_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  b64e_pkg::job_t                  head,
	input  b64e_pkg::q_stat_t               stat,
	input  logic [b64e_pkg::CNT_W-1:0]      cap,
	output logic                            deq,
	input  logic                            pop,
	output logic                            empty,
	output b64e_pkg::out_word_t             out_word
);
	import b64e_pkg::*;

	logic [CNT_W-1:0]  cnt_q;
	logic              ovf_q;
	logic [1:0]        k_q;
	out_word_t         out_q;
	logic              out_v_q;

	logic              skip;
	logic              is_ovf;
	logic [CNT_W-1:0]  cnt_nx;
	logic              last_char;
	logic              job_done;
	logic              emit;
	logic              slot_free;
	logic              go;
	out_word_t         res;

	assign empty     = !out_v_q;
	assign out_word  = out_q;
	assign slot_free = !out_v_q || pop;

	// all chars of a job are dropped once the stream has overflowed
	assign skip      = ovf_q || (head.n == '0);
	assign is_ovf    = (cnt_q >= cap);
	assign cnt_nx    = is_ovf ? cnt_q : cnt_q + 1'b1;
	assign last_char = ((N_W'(k_q) + 1'b1) == head.n);
	// an overflow word is always the final word of its job
	assign job_done  = skip || is_ovf || last_char;
	assign emit      = skip ? head.last : 1'b1;
	assign go        = stat.valid && (!emit || slot_free);
	assign deq       = go && job_done;

	always_comb begin
		res = '0;
		if (skip) begin
			res.stream_end = 1'b1;
			res.overflow   = ovf_q || is_ovf;
			res.char_count = cnt_q;
		end else if (is_ovf) begin
			res.overflow   = 1'b1;
			res.stream_end = head.last;
			res.char_count = cnt_q;
		end else begin
			res.char_code  = head.chars[k_q];
			res.char_valid = 1'b1;
			res.stream_end = head.last && last_char;
			// terminator slot check on the closing char
			res.overflow   = head.last && last_char && (cnt_nx >= cap);
			res.char_count = cnt_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			k_q     <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (go) begin
				if (job_done) begin
					k_q <= '0;
					if (head.last) begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
					end else if (!skip) begin
						cnt_q <= cnt_nx;
						ovf_q <= is_ovf;
					end
				end else begin
					k_q   <= k_q + 1'b1;
					cnt_q <= cnt_nx;
				end
			end
			if (go && emit) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			out_q <= res;
		end
	end

	// a char word carries overflow only as the closing word of its stream
	`B64E_ASSERT_NOW(a_char_not_ovf, out_v_q && out_q.char_valid,
		!out_q.overflow || out_q.stream_end, "char word flagged as overflow")
	`B64E_ASSERT_NEXT(a_close_clears, go && job_done && head.last, cnt_q == '0 && !ovf_q,
		"stream state not cleared after close")
	`B64E_ASSERT_NOW(a_index_in_job, stat.valid && !ovf_q && head.n != '0,
		N_W'(k_q) < head.n, "char index past end of job")

endmodule

// ----- sv/base64_stream_encoder.sv -----
// base64 encoder, standard alphabet with '=' padding, one byte per input word
// input queue side: drive in_word and push; the word is taken at a clock edge
//   with push high and full low. byte_present 0 with is_last 1 closes a stream
//   (also an empty one); byte_present 0 with is_last 0 is ignored
// result queue side: out_word holds the oldest result while empty is low and
//   is taken at an edge with pop high. stream_end marks the closing word and
//   char_count then holds the stream length; overflow flags a full output
// config: cfg_we/cfg_wdata write output_capacity (slots incl. terminator); the user
//   must write it only while the block is idle, which the block leaves unchecked; reset value 65535
// front unit tracks the 3-byte group phase and turns each byte into 1..4
//   chars; a small job queue decouples it from the back unit, which checks
//   capacity and emits one result word per clock while its output slot is free
// an accepted input is held in a job queue slot, then registered into the output word
// throughput: one result word per cycle while pop keeps the output free, set by
//   the single output register; a byte yields 1 or 2 chars, and a stream close
//   with padding yields up to 4
// reset clears phase, counts, queue and output; the capacity goes to 65535
// when pop is held low the output word waits, the job queue fills, then full
//   rises and input stalls; nothing is lost or repeated
module base64_stream_encoder #(
	parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  b64e_pkg::in_word_t          in_word,
	input  logic                        pop,
	output logic                        empty,
	output b64e_pkg::out_word_t         out_word,
	input  logic                        cfg_we,
	input  logic [b64e_pkg::CNT_W-1:0]  cfg_wdata
);
	import b64e_pkg::*;

	// capacity register
	logic [CNT_W-1:0] cap_q;

	// front to queue
	logic    enq;
	job_t    enq_job;

	// queue to back
	job_t    head;
	q_stat_t stat;
	logic    deq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// input stalls only when the job queue is full
	assign full = stat.full;

	b64e_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.in_word(in_word),
		.q_full (stat.full),
		.enq    (enq),
		.job    (enq_job)
	);

	b64e_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.enq    (enq),
		.enq_job(enq_job),
		.deq    (deq),
		.head   (head),
		.stat   (stat)
	);

	b64e_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.stat    (stat),
		.cap     (cap_q),
		.deq     (deq),
		.pop     (pop),
		.empty   (empty),
		.out_word(out_word)
	);

endmodule

// ----- sim/base64_stream_encoder_test.sv -----
module base64_stream_encoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import b64e_pkg::*;

	// predicts the encoder's result words and checks them in order
	class encoder_scoreboard;
		logic [CNT_W-1:0] capacity;
		logic [1:0]       phase;
		logic [3:0]       carry;
		logic [CNT_W-1:0] count;
		bit               over;
		out_word_t        pending_words[$];
		out_word_t        item_words[$];
		int               errors;
		int               reports;
		string            alphabet;

		function new();
			alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
			capacity = CAP_RESET;
			errors   = 0;
			reports  = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			phase = 2'd0;
			carry = 4'd0;
			count = '0;
			over  = 1'b0;
		endfunction

		function logic [CHAR_W-1:0] sextet_to_ascii(logic [5:0] v);
			byte c;
			c = alphabet[v];
			return c[CHAR_W-1:0];
		endfunction

		// one character against the capacity; the first that misses gives an overflow word
		function void put_char(logic [CHAR_W-1:0] ch);
			out_word_t w;
			if (over) return;
			w = '0;
			if (count >= capacity) begin
				over = 1'b1;
				w.overflow   = 1'b1;
				w.char_count = count;
			end else begin
				count = count + 1'b1;
				w.char_code  = ch;
				w.char_valid = 1'b1;
				w.char_count = count;
			end
			item_words.push_back(w);
		endfunction

		function void note_word(in_word_t w);
			out_word_t tail;
			item_words.delete();
			if (w.byte_present && !over) begin
				case (phase)
					2'd0: begin
						put_char(sextet_to_ascii(w.data_byte[7:2]));
						carry = {2'b00, w.data_byte[1:0]};
						phase = 2'd1;
					end
					2'd1: begin
						put_char(sextet_to_ascii({carry[1:0], w.data_byte[7:4]}));
						carry = w.data_byte[3:0];
						phase = 2'd2;
					end
					default: begin
						put_char(sextet_to_ascii({carry, w.data_byte[7:6]}));
						put_char(sextet_to_ascii(w.data_byte[5:0]));
						carry = 4'd0;
						phase = 2'd0;
					end
				endcase
			end
			if (w.is_last) begin
				if (phase == 2'd1) begin
					put_char(sextet_to_ascii({carry[1:0], 4'b0000}));
					put_char(PAD_CHAR);
					put_char(PAD_CHAR);
				end else if (phase == 2'd2) begin
					put_char(sextet_to_ascii({carry, 2'b00}));
					put_char(PAD_CHAR);
				end
				// no room left for the terminator
				if (!over && count >= capacity) over = 1'b1;
				if (item_words.size() == 0) begin
					tail = '0;
					item_words.push_back(tail);
				end
				tail = item_words.pop_back();
				tail.stream_end = 1'b1;
				tail.overflow   = over;
				tail.char_count = count;
				item_words.push_back(tail);
				clear_stream();
			end
			foreach (item_words[k]) pending_words.push_back(item_words[k]);
		endfunction

		function void flag_field(string field, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				errors++;
				if (reports < 40)
					$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
				reports++;
			end
		endfunction

		function void check_word(out_word_t got);
			out_word_t want;
			if (pending_words.size() == 0) begin
				errors++;
				if (reports < 40)
					$display("%0t: word with nothing expected, expected none, got %h",
						$time, got);
				reports++;
				return;
			end
			want = pending_words.pop_front();
			flag_field("char_code", 16'(want.char_code), 16'(got.char_code));
			flag_field("char_valid", 16'(want.char_valid), 16'(got.char_valid));
			flag_field("stream_end", 16'(want.stream_end), 16'(got.stream_end));
			flag_field("overflow", 16'(want.overflow), 16'(got.overflow));
			flag_field("char_count", want.char_count, got.char_count);
		endfunction
	endclass

	localparam int STALL_LIMIT     = 2000; // cycles with no word moving on either side
	localparam int ITEMS_PER_PHASE = 38;
	localparam int TAIL_CYCLES     = 8;

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             push      = 1'b0;
	logic             full;
	in_word_t         in_word   = '0;
	logic             pop       = 1'b0;
	logic             empty;
	out_word_t        out_word;
	logic             cfg_we    = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;

	bit               steady      = 1'b0; // no idling on either side while set
	int               items_sent  = 0;
	int               quiet_cycles = 0;
	encoder_scoreboard sb;

	base64_stream_encoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_word   (in_word),
		.pop       (pop),
		.empty     (empty),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side raises pop at random, 64 times in a hundred, or always while steady is set
	always @(posedge clk) begin
		pop <= steady || ($urandom_range(0, 99) >= 36);
	end

	// both handshakes sampled at the edge, before the block updates
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) sb.note_word(in_word);
			if (pop && !empty) sb.check_word(out_word);
		end
	end

	// watchdog: too long with no word moving means the block is stuck
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// push stays high across back-to-back words; it only drops on an idle cycle
	task automatic send_word(input in_word_t w);
		if (!steady) begin
			while ($urandom_range(0, 99) < 36) begin
				push <= 1'b0;
				@(posedge clk);
			end
		end
		push    <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// stop pushing and let every expected word come out, then a TAIL_CYCLES wait for
	// items that make no word of their own
	task automatic settle_encoder();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending_words.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CNT_W-1:0] value);
		settle_encoder();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.capacity = value;
	endtask

	// one stream of random bytes, closed by a last byte or by a bare end marker,
	// with an occasional marker that means nothing mixed in
	task automatic random_stream(input int nbytes);
		in_word_t w;
		bit       bare_close;
		bare_close = (nbytes == 0) ? 1'b1 : 1'($urandom_range(0, 1));
		for (int k = 0; k < nbytes; k++) begin
			if ($urandom_range(0, 99) < 6) begin
				w.data_byte    = 8'($urandom_range(0, 255));
				w.byte_present = 1'b0;
				w.is_last      = 1'b0;
				send_word(w);
			end
			case ($urandom_range(0, 9))
				0:       w.data_byte = 8'h00;
				1:       w.data_byte = 8'hFF;
				default: w.data_byte = 8'($urandom_range(0, 255));
			endcase
			w.byte_present = 1'b1;
			w.is_last      = !bare_close && (k == nbytes - 1);
			send_word(w);
			items_sent++;
		end
		if (bare_close) begin
			w.data_byte    = 8'($urandom_range(0, 255));
			w.byte_present = 1'b0;
			w.is_last      = 1'b1;
			send_word(w);
			items_sent++;
		end
	endtask

	initial begin
		int target;
		int nbytes;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, capacity at its reset value
		send_word('{8'hA5, 1'b0, 1'b1});  // empty stream
		send_word('{8'h5A, 1'b0, 1'b0});  // bare marker not last, ignored
		send_word('{8'h00, 1'b1, 1'b1});  // one byte, two pads
		send_word('{8'hFF, 1'b1, 1'b0});
		send_word('{8'hFF, 1'b1, 1'b1});  // two bytes, one pad
		send_word('{8'hFB, 1'b1, 1'b0});
		send_word('{8'hEF, 1'b1, 1'b0});
		send_word('{8'hBE, 1'b1, 1'b1});  // full group closed by its last byte
		send_word('{8'h4D, 1'b1, 1'b0});
		send_word('{8'h61, 1'b1, 1'b0});
		send_word('{8'h6E, 1'b1, 1'b0});
		send_word('{8'hC3, 1'b0, 1'b1});  // full group closed by a bare marker
		send_word('{8'h80, 1'b1, 1'b0});
		send_word('{8'h7F, 1'b0, 1'b0});  // ignored marker inside a stream
		send_word('{8'h01, 1'b0, 1'b1});  // bare marker flushes a partial group

		// smallest capacity: a single slot, taken by one char or by the terminator
		write_capacity(16'd1);
		send_word('{8'h00, 1'b0, 1'b1});  // empty stream still fits
		send_word('{8'h12, 1'b1, 1'b0});  // first char still fits in the only slot
		send_word('{8'h34, 1'b1, 1'b1});  // dropped, end word carries overflow

		// four chars fill every slot, terminator overflows
		write_capacity(16'd4);
		send_word('{8'h01, 1'b1, 1'b0});
		send_word('{8'h02, 1'b1, 1'b0});
		send_word('{8'h03, 1'b1, 1'b1});

		// overflow hits on a pad
		write_capacity(16'd3);
		send_word('{8'hAA, 1'b1, 1'b0});
		send_word('{8'hBB, 1'b1, 1'b1});

		// random part over several capacities, extremes among them
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0:       write_capacity(16'hFFFF);
				1:       write_capacity(16'($urandom_range(2, 12)));
				2:       write_capacity(16'd1);
				3:       write_capacity(16'($urandom_range(4, 40)));
				4:       write_capacity(16'($urandom_range(1, 65535)));
				default: write_capacity(16'($urandom_range(13, 30)));
			endcase
			steady = (ph == 3);
			target = items_sent + ITEMS_PER_PHASE;
			while (items_sent < target) begin
				nbytes = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 7)
					: $urandom_range(8, 24);
				random_stream(nbytes);
			end
		end
		steady = 1'b0;

		settle_encoder();
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+sv
sv/b64e_pkg.sv
sv/b64e_front.sv
sv/b64e_queue.sv
sv/b64e_back.sv
sv/base64_stream_encoder.sv
sim/base64_stream_encoder_test.sv
